FILE: rtl/core/triangle_scanline_span_generator_core_defines.svh
// Assertion helpers for the span generator core.
`ifndef TRIANGLE_SCANLINE_SPAN_GENERATOR_CORE_DEFINES_SVH
`define TRIANGLE_SCANLINE_SPAN_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define TSSG_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define TSSG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/triscan_pkg.sv
package triscan_pkg;

    localparam int COORD_BITS    = 12;
    localparam int SCREEN_WIDTH  = 240;
    localparam int SCREEN_HEIGHT = 320;
    localparam int RGB_W         = 16;
    localparam int XOUT_W        = 8;

    // edge delta, product of two deltas, divider count, working x width
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int CNT_W  = $clog2(PROD_W);
    localparam int XW     = COORD_BITS + 2;

    // command queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [XW-1:0]         xw_t;

    typedef struct packed {
        logic             is_load;
        coord_t           ax;
        coord_t           ay;
        coord_t           bx;
        coord_t           by;
        coord_t           cx;
        coord_t           cy;
        logic [RGB_W-1:0] rgb;
    } cmd_t;

    typedef struct packed {
        logic  start;
        prod_t num;
        diff_t den;
    } div_req_t;

    typedef struct packed {
        logic  busy;
        logic  done;
        diff_t quo;
    } div_rsp_t;

endpackage

FILE: rtl/core/triscan_front.sv
module triscan_front
    import triscan_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_req_type,
    input  coord_t           s_ax,
    input  coord_t           s_ay,
    input  coord_t           s_bx,
    input  coord_t           s_by,
    input  coord_t           s_cx,
    input  coord_t           s_cy,
    input  logic [RGB_W-1:0] s_fill_rgb,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output cmd_t             cmd
);

    cmd_t              queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    cmd_t              in_cmd;
    logic              push;
    logic              pop;

    // classify the incoming item
    always_comb begin
        in_cmd.is_load = (s_req_type == REQ_LOAD);
        in_cmd.ax      = s_ax;
        in_cmd.ay      = s_ay;
        in_cmd.bx      = s_bx;
        in_cmd.by      = s_by;
        in_cmd.cx      = s_cx;
        in_cmd.cy      = s_cy;
        in_cmd.rgb     = s_fill_rgb;
    end

    assign s_ready   = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_mem[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/core/triscan_div.sv
module triscan_div
    import triscan_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIFF_W-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [DIFF_W-1:0] dmag_reg, dmag_next;
    logic              neg_reg, neg_next;
    logic [PROD_W-1:0] num_mag;
    logic [DIFF_W-1:0] den_mag;
    logic [DIFF_W:0]   rem_sh;
    logic [DIFF_W:0]   trial;
    logic              fits;
    logic [DIFF_W-1:0] quo_low;

    assign num_mag = req.num[PROD_W-1] ? (~req.num + 1'b1) : req.num;
    assign den_mag = req.den[DIFF_W-1] ? (~req.den + 1'b1) : req.den;

    // restoring step: one quotient bit per cycle
    assign rem_sh = {rem_reg, quo_reg[PROD_W-1]};
    assign trial  = rem_sh - {1'b0, dmag_reg};
    assign fits   = !trial[DIFF_W];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = num_mag;
            dmag_next = den_mag;
            neg_next  = req.num[PROD_W-1] ^ req.den[DIFF_W-1];
        end else if (busy_reg) begin
            rem_next = fits ? trial[DIFF_W-1:0] : rem_sh[DIFF_W-1:0];
            quo_next = {quo_reg[PROD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(PROD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // quotient of an in-range edge always fits the delta width
    assign quo_low  = quo_reg[DIFF_W-1:0];
    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = neg_reg ? diff_t'(~quo_low + 1'b1) : diff_t'(quo_low);

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

FILE: rtl/core/triscan_back.sv
module triscan_back
    import triscan_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd,
    output div_req_t          div_req,
    input  div_rsp_t          div_rsp,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_span_drawn,
    output coord_t            m_row_y,
    output logic [XOUT_W-1:0] m_x_start,
    output logic [XOUT_W-1:0] m_x_end,
    output logic [RGB_W-1:0]  m_span_rgb,
    output logic              m_last_row
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SETUP  = 3'd1;
    localparam logic [2:0] ST_START  = 3'd2;
    localparam logic [2:0] ST_WAIT   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    localparam xw_t SCR_W = xw_t'(SCREEN_WIDTH);
    localparam xw_t SCR_H = xw_t'(SCREEN_HEIGHT);

    logic [2:0]       state_reg, state_next;
    coord_t           top_x_reg, top_x_next, top_y_reg, top_y_next;
    coord_t           mid_x_reg, mid_x_next, mid_y_reg, mid_y_next;
    coord_t           bot_x_reg, bot_x_next, bot_y_reg, bot_y_next;
    logic [RGB_W-1:0] rgb_reg, rgb_next;
    coord_t           row_reg, row_next;
    logic             active_reg, active_next;
    logic             edge_reg, edge_next;
    prod_t            num_reg, num_next;
    diff_t            den_reg, den_next;
    coord_t           xs_reg, xs_next;
    logic             flat_reg, flat_next;
    xw_t              xa_reg, xa_next, xb_reg, xb_next;

    logic              m_valid_reg, m_valid_next;
    logic              drawn_reg, drawn_next;
    coord_t            orow_reg, orow_next;
    logic [XOUT_W-1:0] xs_out_reg, xs_out_next, xe_out_reg, xe_out_next;
    logic [RGB_W-1:0]  orgb_reg, orgb_next;
    logic              last_reg, last_next;

    // sort network signals
    coord_t sx0, sy0, sx1, sy1, sx2, sy2, tx, ty;
    // edge select
    coord_t e_xs, e_ys, e_xe, e_ye;
    diff_t  dx, dy;
    // edge result
    logic   edge_fin;
    xw_t    edge_val;
    // span finish
    xw_t    lo, hi, lo_c, hi_c, y_w;
    logic   drawn, last, out_free;

    // three compare-swaps on y: (0,1), (1,2), (0,1)
    always_comb begin
        sx0 = cmd.ax; sy0 = cmd.ay;
        sx1 = cmd.bx; sy1 = cmd.by;
        sx2 = cmd.cx; sy2 = cmd.cy;
        tx  = sx0;    ty  = sy0;
        if (sy0 > sy1) begin
            tx = sx0; ty = sy0;
            sx0 = sx1; sy0 = sy1;
            sx1 = tx;  sy1 = ty;
        end
        if (sy1 > sy2) begin
            tx = sx1; ty = sy1;
            sx1 = sx2; sy1 = sy2;
            sx2 = tx;  sy2 = ty;
        end
        if (sy0 > sy1) begin
            tx = sx0; ty = sy0;
            sx0 = sx1; sy0 = sy1;
            sx1 = tx;  sy1 = ty;
        end
    end

    // first edge: top-mid above the middle row, mid-bottom otherwise;
    // second edge: top-bottom
    always_comb begin
        if (edge_reg) begin
            e_xs = top_x_reg; e_ys = top_y_reg;
            e_xe = bot_x_reg; e_ye = bot_y_reg;
        end else if (row_reg < mid_y_reg) begin
            e_xs = top_x_reg; e_ys = top_y_reg;
            e_xe = mid_x_reg; e_ye = mid_y_reg;
        end else begin
            e_xs = mid_x_reg; e_ys = mid_y_reg;
            e_xe = bot_x_reg; e_ye = bot_y_reg;
        end
        dx = diff_t'(e_xe) - diff_t'(e_xs);
        dy = diff_t'(row_reg) - diff_t'(e_ys);
    end

    // flat edge gives its start x without a divide
    always_comb begin
        edge_fin = 1'b0;
        edge_val = xw_t'(xs_reg);
        if (state_reg == ST_START && flat_reg) begin
            edge_fin = 1'b1;
        end else if (state_reg == ST_WAIT && div_rsp.done) begin
            edge_fin = 1'b1;
            edge_val = xw_t'(xs_reg) + xw_t'(div_rsp.quo);
        end
    end

    // order, visibility and clipping of the span
    always_comb begin
        if (xa_reg > xb_reg) begin
            lo = xb_reg; hi = xa_reg;
        end else begin
            lo = xa_reg; hi = xb_reg;
        end
        y_w   = xw_t'(row_reg);
        drawn = !y_w[XW-1] && (y_w < SCR_H) && !hi[XW-1] && (lo < SCR_W);
        lo_c  = lo[XW-1] ? '0 : lo;
        hi_c  = (hi >= SCR_W) ? SCR_W - 1'b1 : hi;
        last  = (row_reg >= bot_y_reg);
    end

    assign out_free      = !m_valid_reg || m_ready;
    assign cmd_ready     = (state_reg == ST_IDLE);
    assign div_req.start = (state_reg == ST_START) && !flat_reg;
    assign div_req.num   = num_reg;
    assign div_req.den   = den_reg;

    always_comb begin
        state_next  = state_reg;
        top_x_next  = top_x_reg;  top_y_next = top_y_reg;
        mid_x_next  = mid_x_reg;  mid_y_next = mid_y_reg;
        bot_x_next  = bot_x_reg;  bot_y_next = bot_y_reg;
        rgb_next    = rgb_reg;
        row_next    = row_reg;
        active_next = active_reg;
        edge_next   = edge_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        xs_next     = xs_reg;
        flat_next   = flat_reg;
        xa_next     = xa_reg;
        xb_next     = xb_reg;

        m_valid_next = m_valid_reg && !m_ready;
        drawn_next   = drawn_reg;
        orow_next    = orow_reg;
        xs_out_next  = xs_out_reg;
        xe_out_next  = xe_out_reg;
        orgb_next    = orgb_reg;
        last_next    = last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.is_load) begin
                        top_x_next  = sx0; top_y_next = sy0;
                        mid_x_next  = sx1; mid_y_next = sy1;
                        bot_x_next  = sx2; bot_y_next = sy2;
                        rgb_next    = cmd.rgb;
                        row_next    = sy0;
                        active_next = 1'b1;
                    end else if (active_reg) begin
                        edge_next  = 1'b0;
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                num_next   = prod_t'(dx) * prod_t'(dy);
                den_next   = diff_t'(e_ye) - diff_t'(e_ys);
                xs_next    = e_xs;
                flat_next  = (e_ye == e_ys);
                state_next = ST_START;
            end
            ST_START, ST_WAIT: begin
                if (state_reg == ST_START && !flat_reg) begin
                    state_next = ST_WAIT;
                end
                if (edge_fin) begin
                    if (edge_reg) begin
                        xb_next    = edge_val;
                        state_next = ST_FINISH;
                    end else begin
                        xa_next    = edge_val;
                        edge_next  = 1'b1;
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    drawn_next   = drawn;
                    orow_next    = row_reg;
                    xs_out_next  = drawn ? lo_c[XOUT_W-1:0] : '0;
                    xe_out_next  = drawn ? hi_c[XOUT_W-1:0] : '0;
                    orgb_next    = rgb_reg;
                    last_next    = last;
                    if (last) begin
                        active_next = 1'b0;
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        edge_reg   <= edge_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        xs_reg     <= xs_next;
        flat_reg   <= flat_next;
        xa_reg     <= xa_next;
        xb_reg     <= xb_next;
        drawn_reg  <= drawn_next;
        orow_reg   <= orow_next;
        xs_out_reg <= xs_out_next;
        xe_out_reg <= xe_out_next;
        orgb_reg   <= orgb_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            top_x_reg   <= '0; top_y_reg <= '0;
            mid_x_reg   <= '0; mid_y_reg <= '0;
            bot_x_reg   <= '0; bot_y_reg <= '0;
            rgb_reg     <= '0;
            row_reg     <= '0;
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            top_x_reg   <= top_x_next; top_y_reg <= top_y_next;
            mid_x_reg   <= mid_x_next; mid_y_reg <= mid_y_next;
            bot_x_reg   <= bot_x_next; bot_y_reg <= bot_y_next;
            rgb_reg     <= rgb_next;
            row_reg     <= row_next;
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_span_drawn = drawn_reg;
    assign m_row_y      = orow_reg;
    assign m_x_start    = xs_out_reg;
    assign m_x_end      = xe_out_reg;
    assign m_span_rgb   = orgb_reg;
    assign m_last_row   = last_reg;

endmodule

FILE: rtl/core/triangle_scanline_span_generator_core.sv
// Scanline span generator for flat-colored triangles.
// Input channel (s_*): req_type 0 loads three signed vertices and a color, no result;
// req_type 1 asks for the next row span. A step with no triangle in progress is
// dropped without a result. Output channel (m_*): one span item per step: row,
// clipped x range, color, drawn flag and last-row mark. After the last row the
// block goes idle until the next load.
// Items enter a two-deep command queue and are carried out one at a time. A load
// is handled in the idle state of the back end. A step computes both edges, each
// by a multiply then a shared restoring divider at one quotient bit a cycle, and
// a flat edge skips its divide. The back end takes a new item only when idle, so
// the next item waits in the queue until the step's span is in the output register.
// When m_ready is low the finished span waits in the output register while the
// queue keeps taking items; s_ready drops only when the queue is full.
// Reset (aresetn low, synchronous) empties the queue, clears the triangle state
// to zero and leaves the block idle.
`include "triangle_scanline_span_generator_core_defines.svh"

module triangle_scanline_span_generator_core
    import triscan_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_req_type,
    input  coord_t            s_ax,
    input  coord_t            s_ay,
    input  coord_t            s_bx,
    input  coord_t            s_by,
    input  coord_t            s_cx,
    input  coord_t            s_cy,
    input  logic [RGB_W-1:0]  s_fill_rgb,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_span_drawn,
    output coord_t            m_row_y,
    output logic [XOUT_W-1:0] m_x_start,
    output logic [XOUT_W-1:0] m_x_end,
    output logic [RGB_W-1:0]  m_span_rgb,
    output logic              m_last_row
);

    // front end -> back end command queue
    logic     cmd_valid;
    logic     cmd_ready;
    cmd_t     cmd;
    // back end <-> shared divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    // accepts and classifies items, buffers them
    triscan_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_ax       (s_ax),
        .s_ay       (s_ay),
        .s_bx       (s_bx),
        .s_by       (s_by),
        .s_cx       (s_cx),
        .s_cy       (s_cy),
        .s_fill_rgb (s_fill_rgb),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    // triangle state, row sequencer, span clip and output register
    triscan_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_span_drawn (m_span_drawn),
        .m_row_y      (m_row_y),
        .m_x_start    (m_x_start),
        .m_x_end      (m_x_end),
        .m_span_rgb   (m_span_rgb),
        .m_last_row   (m_last_row)
    );

    // signed serial divider, truncates toward zero
    triscan_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // undrawn spans carry zero ends
    `TSSG_ASSERT_IMPL(a_undrawn_zero, aclk, aresetn, m_valid && !m_span_drawn, (m_x_start == '0) && (m_x_end == '0), "undrawn span with nonzero ends")
    // drawn spans are ordered and on screen
    `TSSG_ASSERT_IMPL(a_span_clip, aclk, aresetn, m_valid && m_span_drawn, (m_x_start <= m_x_end) && (m_x_end < XOUT_W'(SCREEN_WIDTH)), "drawn span not ordered or not clipped")
    // the divider is never restarted mid-operation
    `TSSG_ASSERT_IMPL(a_div_start_idle, aclk, aresetn, div_req.start, !div_rsp.busy && !div_rsp.done, "divider started while busy")
    // a start always launches the divider
    `TSSG_ASSERT_NEXT(a_div_launch, aclk, aresetn, div_req.start, div_rsp.busy, "divider did not start")

endmodule

FILE: tb/span_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the span generator, predicts each span and compares.
module span_checker
    import triscan_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic              s_req_type,
    input  coord_t            s_ax,
    input  coord_t            s_ay,
    input  coord_t            s_bx,
    input  coord_t            s_by,
    input  coord_t            s_cx,
    input  coord_t            s_cy,
    input  logic [RGB_W-1:0]  s_fill_rgb,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic              m_span_drawn,
    input  coord_t            m_row_y,
    input  logic [XOUT_W-1:0] m_x_start,
    input  logic [XOUT_W-1:0] m_x_end,
    input  logic [RGB_W-1:0]  m_span_rgb,
    input  logic              m_last_row,
    output int                span_errors,
    output int                spans_owed
);

    typedef struct packed {
        logic              drawn;
        coord_t            row;
        logic [XOUT_W-1:0] x0;
        logic [XOUT_W-1:0] x1;
        logic [RGB_W-1:0]  rgb;
        logic              last;
    } span_t;

    span_t expected_spans [$];

    // sorted triangle and row walk
    coord_t           top_x, top_y, mid_x, mid_y, bot_x, bot_y;
    coord_t           next_row;
    logic [RGB_W-1:0] held_rgb;
    bit               tri_active;

    task automatic report_mismatch(input string msg);
        $display("%0t span_checker: %s", $time, msg);
        span_errors++;
    endtask

    task automatic compare_field(input string name, input int row, input int got,
                                 input int want);
        if (got != want)
            report_mismatch($sformatf("row %0d %s: got %0d, expected %0d",
                                      row, name, got, want));
    endtask

    // x on the edge (xs,ys)-(xe,ye) at row y; division truncates toward zero
    function automatic longint edge_at(input longint xs, input longint ys, input longint xe,
                                       input longint ye, input longint y);
        if (ye == ys)
            return xs;
        return xs + ((xe - xs) * (y - ys)) / (ye - ys);
    endfunction

    task automatic load_triangle(input coord_t ax, input coord_t ay, input coord_t bx,
                                 input coord_t by, input coord_t cx, input coord_t cy,
                                 input logic [RGB_W-1:0] rgb);
        coord_t vx [3];
        coord_t vy [3];
        coord_t t;
        int     i;
        vx[0] = ax; vy[0] = ay;
        vx[1] = bx; vy[1] = by;
        vx[2] = cx; vy[2] = cy;
        // compare-swap (a,b), (b,c), (a,b); strict greater only
        for (int s = 0; s < 3; s++) begin
            i = (s == 1) ? 1 : 0;
            if (vy[i] > vy[i+1]) begin
                t = vy[i]; vy[i] = vy[i+1]; vy[i+1] = t;
                t = vx[i]; vx[i] = vx[i+1]; vx[i+1] = t;
            end
        end
        top_x = vx[0]; top_y = vy[0];
        mid_x = vx[1]; mid_y = vy[1];
        bot_x = vx[2]; bot_y = vy[2];
        held_rgb   = rgb;
        next_row   = vy[0];
        tri_active = 1'b1;
    endtask

    task automatic step_triangle(output span_t sp);
        longint y, xa, xb, t;
        logic   on;
        y = longint'(next_row);
        if (y < mid_y)
            xa = edge_at(longint'(top_x), longint'(top_y), longint'(mid_x),
                         longint'(mid_y), y);
        else
            xa = edge_at(longint'(mid_x), longint'(mid_y), longint'(bot_x),
                         longint'(bot_y), y);
        xb = edge_at(longint'(top_x), longint'(top_y), longint'(bot_x), longint'(bot_y), y);
        if (xa > xb) begin
            t = xa; xa = xb; xb = t;
        end
        on = !(y < 0 || y >= SCREEN_HEIGHT || xb < 0 || xa >= SCREEN_WIDTH);
        if (on) begin
            if (xa < 0) xa = 0;
            if (xb >= SCREEN_WIDTH) xb = SCREEN_WIDTH - 1;
        end else begin
            xa = 0;
            xb = 0;
        end
        sp.drawn = on;
        sp.row   = coord_t'(y);
        sp.x0    = xa[XOUT_W-1:0];
        sp.x1    = xb[XOUT_W-1:0];
        sp.rgb   = held_rgb;
        sp.last  = (y >= bot_y);
        if (sp.last)
            tri_active = 1'b0;
        else
            next_row = coord_t'(y + 1);
    endtask

    always @(posedge aclk) begin
        span_t sp;
        span_t want;
        if (!aresetn) begin
            top_x = '0; top_y = '0; mid_x = '0; mid_y = '0; bot_x = '0; bot_y = '0;
            next_row    = '0;
            held_rgb    = '0;
            tri_active  = 1'b0;
            span_errors = 0;
            expected_spans.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (s_req_type == REQ_LOAD) begin
                    load_triangle(s_ax, s_ay, s_bx, s_by, s_cx, s_cy, s_fill_rgb);
                end else if (tri_active) begin
                    step_triangle(sp);
                    expected_spans.push_back(sp);
                end
            end
            if (m_valid && m_ready) begin
                if (expected_spans.size() == 0) begin
                    report_mismatch($sformatf("span item for row %0d with none expected",
                                              m_row_y));
                end else begin
                    want = expected_spans.pop_front();
                    compare_field("span_drawn", int'(want.row), int'(m_span_drawn),
                                  int'(want.drawn));
                    compare_field("row_y", int'(want.row), int'(m_row_y), int'(want.row));
                    compare_field("x_start", int'(want.row), int'(m_x_start),
                                  int'(want.x0));
                    compare_field("x_end", int'(want.row), int'(m_x_end), int'(want.x1));
                    compare_field("span_rgb", int'(want.row), int'(m_span_rgb),
                                  int'(want.rgb));
                    compare_field("last_row", int'(want.row), int'(m_last_row),
                                  int'(want.last));
                end
            end
        end
        spans_owed = expected_spans.size();
    end

endmodule

FILE: tb/triangle_scanline_span_generator_core_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the triangle span generator. The span_checker
// beside the block predicts and compares every span item; this module only
// feeds triangles and row steps, paces the result side and decides the end.
module triangle_scanline_span_generator_core_tb;
    import triscan_pkg::*;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_req_type;
    coord_t            s_ax, s_ay, s_bx, s_by, s_cx, s_cy;
    logic [RGB_W-1:0]  s_fill_rgb;
    logic              m_valid;
    logic              m_ready;
    logic              m_span_drawn;
    coord_t            m_row_y;
    logic [XOUT_W-1:0] m_x_start;
    logic [XOUT_W-1:0] m_x_end;
    logic [RGB_W-1:0]  m_span_rgb;
    logic              m_last_row;

    int span_errors;
    int spans_owed;
    int spans_taken   = 0;  // result items taken, drives the long hold-offs
    int counted_items = 0;  // loads, and steps that make a span; idle steps left out
    bit tx_steady     = 1'b0;
    bit rx_steady     = 1'b0;

    triangle_scanline_span_generator_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_ax         (s_ax),
        .s_ay         (s_ay),
        .s_bx         (s_bx),
        .s_by         (s_by),
        .s_cx         (s_cx),
        .s_cy         (s_cy),
        .s_fill_rgb   (s_fill_rgb),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_span_drawn (m_span_drawn),
        .m_row_y      (m_row_y),
        .m_x_start    (m_x_start),
        .m_x_end      (m_x_end),
        .m_span_rgb   (m_span_rgb),
        .m_last_row   (m_last_row)
    );

    span_checker u_span_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_ax         (s_ax),
        .s_ay         (s_ay),
        .s_bx         (s_bx),
        .s_by         (s_by),
        .s_cx         (s_cx),
        .s_cy         (s_cy),
        .s_fill_rgb   (s_fill_rgb),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_span_drawn (m_span_drawn),
        .m_row_y      (m_row_y),
        .m_x_start    (m_x_start),
        .m_x_end      (m_x_end),
        .m_span_rgb   (m_span_rgb),
        .m_last_row   (m_last_row),
        .span_errors  (span_errors),
        .spans_owed   (spans_owed)
    );

    // 12 ns clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Run limit. The slowest correct run is roughly 1500 items plus sender gaps,
    // receiver stalls and two long hold-offs, well inside the 20 ms limit.
    initial begin
        #20_000_000;
        $display("triangle_scanline_span_generator_core_tb: done, errors");
        $finish;
    end

    always @(posedge aclk)
        if (m_valid && m_ready)
            spans_taken <= spans_taken + 1;

    // Idle length for either side: mostly none or short, a few long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    // Offer one item and hold it until taken. Entered and left at a falling
    // edge; s_valid stays high between back-to-back items with no gap.
    task automatic send_item(input logic req, input int ax, input int ay, input int bx,
                             input int by, input int cx, input int cy,
                             input logic [RGB_W-1:0] rgb);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_ax       <= coord_t'(ax);
        s_ay       <= coord_t'(ay);
        s_bx       <= coord_t'(bx);
        s_by       <= coord_t'(by);
        s_cx       <= coord_t'(cx);
        s_cy       <= coord_t'(cy);
        s_fill_rgb <= rgb;
        @(posedge aclk);
        while (!(s_valid && s_ready))
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic load_tri(input int ax, input int ay, input int bx, input int by,
                            input int cx, input int cy, input logic [RGB_W-1:0] rgb);
        send_item(REQ_LOAD, ax, ay, bx, by, cx, cy, rgb);
        counted_items++;
    endtask

    // Step item; the vertex and color fields are ignored, so fill them with noise.
    task automatic step_row();
        send_item(REQ_STEP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  RGB_W'($urandom));
    endtask

    // One random triangle, mostly walked to its last row. Heights are mostly
    // small to keep the run short; rows land near the screen about half the
    // time and anywhere in the coordinate range otherwise.
    task automatic random_triangle();
        int h, base, r, j, t, steps;
        int ys [3];
        int xs [3];
        r = $urandom_range(0, 99);
        if (r < 85)
            h = $urandom_range(0, 24);
        else if (r < 97)
            h = $urandom_range(25, 120);
        else
            h = $urandom_range(121, 300);
        if ($urandom_range(0, 1))
            base = int'($urandom_range(0, 4095 - h)) - 2048;
        else
            base = int'($urandom_range(0, 380)) - 40 - h / 2;
        ys[0] = base;
        ys[1] = base + h;
        // flat top or flat bottom now and then
        r = $urandom_range(0, 99);
        if (r < 8)
            ys[2] = ys[0];
        else if (r < 16)
            ys[2] = ys[1];
        else
            ys[2] = base + int'($urandom_range(0, h));
        for (int k = 0; k < 3; k++) begin
            if ($urandom_range(0, 9) < 7)
                xs[k] = int'($urandom_range(0, 360)) - 60;
            else
                xs[k] = int'($urandom_range(0, 4095)) - 2048;
        end
        // shuffle the y values so every sort path gets used
        for (int k = 2; k > 0; k--) begin
            j = $urandom_range(0, k);
            t = ys[k]; ys[k] = ys[j]; ys[j] = t;
        end
        load_tri(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], RGB_W'($urandom));
        // cut short now and then: the next load restarts mid-triangle
        if ($urandom_range(0, 99) < 15)
            steps = $urandom_range(0, h);
        else
            steps = h + 1;
        repeat (steps) begin
            step_row();
            counted_items++;
        end
        // extra uncounted steps; after a full walk they are past the last row and give nothing
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2)) step_row();
    endtask

    // Result side: random stalls, stretches of none, and two long hold-offs
    // during which the sender keeps offering so the queue fills and s_ready drops.
    initial begin : result_pacing
        int stall;
        int hold;
        int next_hold;
        stall     = 0;
        hold      = 0;
        next_hold = 30;
        m_ready   = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (next_hold > 0 && spans_taken >= next_hold) begin
                hold      = 500;
                next_hold = (next_hold == 30) ? 400 : 0;
            end
            if ($urandom_range(0, 299) == 0)
                rx_steady = !rx_steady;
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 3) == 0)
                    stall = idle_len();
            end
        end
    end

    initial begin
        // every input known from time zero
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_req_type = REQ_LOAD;
        s_ax       = '0;
        s_ay       = '0;
        s_bx       = '0;
        s_by       = '0;
        s_cx       = '0;
        s_cy       = '0;
        s_fill_rgb = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part.
        // Step right after reset: nothing is in progress, so no span.
        step_row();
        // All three compare-swaps fire; rows -1..3 cross the top of the screen,
        // left end clamped. One extra step after the last row is dropped.
        load_tri(10, 3, 200, 1, -30, -1, 16'hA5A5);
        repeat (5) step_row();
        step_row();
        // Flat top at the coordinate extremes, rows 318..320 cross the bottom
        // of the screen; both ends clamped.
        load_tri(2047, 318, -2048, 318, 100, 320, 16'hFFFF);
        repeat (3) step_row();
        // Lowest rows of the coordinate range: off screen, black.
        load_tri(0, -2048, 5, -2047, -5, -2048, 16'h0000);
        repeat (2) step_row();
        // Highest rows of the coordinate range, flat bottom.
        load_tri(1, 2046, 2, 2047, 3, 2047, 16'h8001);
        repeat (2) step_row();
        // Span wholly right of the screen; a load in the middle restarts.
        load_tri(240, 10, 300, 11, 260, 10, 16'h1234);
        step_row();
        // Single point: every edge flat, one row that is also the last.
        load_tri(50, 50, 50, 50, 50, 50, 16'h5678);
        step_row();
        // Span wholly left of the screen.
        load_tri(-100, 0, -10, 1, -50, 1, 16'h0F0F);
        repeat (2) step_row();

        // Random part: mostly whole triangles, some cut short, some stray steps.
        while (counted_items < 1150) begin
            if ($urandom_range(0, 99) < 8)
                repeat ($urandom_range(1, 3)) step_row();
            else
                random_triangle();
        end
        s_valid <= 1'b0;

        // drain, then allow for a dropped step still in the back end
        while (spans_owed != 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);

        if (span_errors == 0 && spans_owed == 0)
            $display("triangle_scanline_span_generator_core_tb: done, clean");
        else
            $display("triangle_scanline_span_generator_core_tb: done, errors");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/triscan_pkg.sv
rtl/core/triscan_front.sv
rtl/core/triscan_div.sv
rtl/core/triscan_back.sv
rtl/core/triangle_scanline_span_generator_core.sv
tb/span_checker.sv
tb/triangle_scanline_span_generator_core_tb.sv
